/* sv/cokg_pkg.sv */
package cokg_pkg;

   // request codes
   typedef enum logic [1:0] {
      OP_LOAD     = 2'd0,
      OP_SET      = 2'd1,
      OP_RESTART  = 2'd2,
      OP_GENERATE = 2'd3
   } op_type;

   // configuration register indexes
   localparam logic [1:0] CSR_PASSWORD_LENGTH  = 2'd0;
   localparam logic [1:0] CSR_CHARSET_COUNT    = 2'd1;
   localparam logic [1:0] CSR_FIXED_PREFIX_LEN = 2'd2;

   localparam logic [7:0] END_MARK   = 8'h80;
   localparam int         CAND_BYTES = 16;
   localparam int         CAND_WORDS = 4;

   // classified request as held in the queue
   typedef struct packed {
      op_type     op;
      logic       keep;
      logic [7:0] slot;
      logic [7:0] code;
      logic [3:0] position;
      logic [7:0] digit;
   } cmd_type;

   // effective configuration, length and count already clamped
   typedef struct packed {
      logic [3:0] len;
      logic [8:0] count;
      logic [3:0] prefix;
   } cfg_type;

endpackage

/* sv/cokg_ram.sv */
module cokg_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/cokg_front.sv */
module cokg_front #(
   parameter int MAX_LEN    = 15,
   parameter int TABLE_SIZE = 256
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [1:0]       req_op,
   input  logic [7:0]       req_table_slot,
   input  logic [7:0]       req_char_code,
   input  logic [3:0]       req_position,
   input  logic [7:0]       req_start_digit,
   output logic             q_valid,
   output cokg_pkg::cmd_type q_cmd,
   input  logic             q_pop
);

   localparam int QD = 2;

   cokg_pkg::cmd_type entry_ff [QD];
   cokg_pkg::cmd_type cmd_in;
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        count_ff, count_in;
   logic              push;

   // classify: out-of-range loads and sets become no-ops
   always_comb begin
      cmd_in.op       = cokg_pkg::op_type'(req_op);
      cmd_in.slot     = req_table_slot;
      cmd_in.code     = req_char_code;
      cmd_in.position = req_position;
      cmd_in.digit    = req_start_digit;
      case (cmd_in.op)
         cokg_pkg::OP_LOAD: cmd_in.keep = {1'b0, req_table_slot} < 9'(TABLE_SIZE);
         cokg_pkg::OP_SET:  cmd_in.keep = {1'b0, req_position} < 5'(MAX_LEN);
         default:           cmd_in.keep = 1'b1;
      endcase
   end

   assign req_stall = (count_ff == 2'(QD));
   assign push      = req_valid & ~req_stall;
   assign q_valid   = (count_ff != 2'd0);
   assign q_cmd     = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ q_pop;
      count_in  = count_ff + 2'(push) - 2'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= cmd_in;
      end
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

/* sv/cokg_back.sv */
module cokg_back #(
   parameter int MAX_LEN    = 15,
   parameter int TABLE_SIZE = 256
) (
   input  logic              clock,
   input  logic              reset,
   input  cokg_pkg::cfg_type cfg,
   input  logic              q_valid,
   input  cokg_pkg::cmd_type q_cmd,
   output logic              q_pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [31:0]       rsp_word0,
   output logic [31:0]       rsp_word1,
   output logic [31:0]       rsp_word2,
   output logic [31:0]       rsp_word3,
   output logic              rsp_exhausted
);

   localparam int DIW = MAX_LEN > 1 ? $clog2(MAX_LEN) : 1;
   localparam int TAW = $clog2(TABLE_SIZE);

   typedef enum logic [1:0] {
      S_IDLE,
      S_FETCH,
      S_ADVANCE,
      S_EMIT
   } state_type;

   state_type   state_ff, state_in;
   logic [7:0]  digit_ff [MAX_LEN];
   logic [7:0]  digit_in [MAX_LEN];
   logic [7:0]  bytes_ff [cokg_pkg::CAND_BYTES];
   logic [7:0]  bytes_in [cokg_pkg::CAND_BYTES];
   logic [31:0] words_ff [cokg_pkg::CAND_WORDS];
   logic [31:0] words_in [cokg_pkg::CAND_WORDS];
   logic        done_ff, done_in;
   logic [3:0]  rd_idx_ff, rd_idx_in;
   logic [3:0]  adv_pos_ff, adv_pos_in;
   logic        pend_ff, pend_in;
   logic [3:0]  pend_idx_ff, pend_idx_in;
   logic        oob_ff, oob_in;
   logic        out_valid_ff, out_valid_in;
   logic        exh_ff, exh_in;

   logic [7:0]     rd_digit;
   logic [7:0]     adv_digit;
   logic [8:0]     adv_sum;
   logic           ram_we;
   logic [TAW-1:0] ram_raddr;
   logic [7:0]     ram_rdata;

   assign rd_digit  = digit_ff[rd_idx_ff[DIW-1:0]];
   assign adv_digit = digit_ff[adv_pos_ff[DIW-1:0]];
   assign adv_sum   = {1'b0, adv_digit} + 9'd1;
   assign ram_raddr = rd_digit[TAW-1:0];

   cokg_ram #(
      .WIDTH (8),
      .DEPTH (TABLE_SIZE)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (q_cmd.slot[TAW-1:0]),
      .wr_data (q_cmd.code),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   always_comb begin
      state_in     = state_ff;
      digit_in     = digit_ff;
      bytes_in     = bytes_ff;
      words_in     = words_ff;
      done_in      = done_ff;
      rd_idx_in    = rd_idx_ff;
      adv_pos_in   = adv_pos_ff;
      pend_in      = 1'b0;
      pend_idx_in  = pend_idx_ff;
      oob_in       = oob_ff;
      out_valid_in = out_valid_ff & rsp_stall;
      exh_in       = exh_ff;
      q_pop        = 1'b0;
      ram_we       = 1'b0;

      // table read data lands in the cycle after the fetch
      if (pend_ff) begin
         bytes_in[pend_idx_ff] = oob_ff ? 8'd0 : ram_rdata;
      end

      case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               case (q_cmd.op)
                  cokg_pkg::OP_LOAD: begin
                     ram_we = q_cmd.keep;
                  end
                  cokg_pkg::OP_SET: begin
                     if (q_cmd.keep) begin
                        digit_in[q_cmd.position[DIW-1:0]] = q_cmd.digit;
                     end
                  end
                  cokg_pkg::OP_RESTART: begin
                     for (int i = 0; i < MAX_LEN; i++) begin
                        digit_in[i] = 8'd0;
                     end
                     done_in = 1'b0;
                  end
                  cokg_pkg::OP_GENERATE: begin
                     for (int i = 0; i < cokg_pkg::CAND_BYTES; i++) begin
                        bytes_in[i] = 8'd0;
                     end
                     bytes_in[cfg.len] = cokg_pkg::END_MARK;
                     rd_idx_in  = 4'd0;
                     adv_pos_in = cfg.len - 4'd1;
                     state_in   = (cfg.len == 4'd0) ? S_ADVANCE : S_FETCH;
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_FETCH: begin
            pend_in     = 1'b1;
            pend_idx_in = rd_idx_ff;
            oob_in      = {1'b0, rd_digit} >= 9'(TABLE_SIZE);
            if (rd_idx_ff == cfg.len - 4'd1) begin
               state_in = S_ADVANCE;
            end else begin
               rd_idx_in = rd_idx_ff + 4'd1;
            end
         end
         S_ADVANCE: begin
            // one position of the carry walk per cycle
            if (cfg.len == 4'd0) begin
               done_in  = 1'b1;
               state_in = S_EMIT;
            end else if (adv_sum < cfg.count) begin
               digit_in[adv_pos_ff[DIW-1:0]] = adv_sum[7:0];
               state_in = S_EMIT;
            end else begin
               digit_in[adv_pos_ff[DIW-1:0]] = 8'd0;
               if (adv_pos_ff == 4'd0 || adv_pos_ff <= cfg.prefix) begin
                  done_in  = 1'b1;
                  state_in = S_EMIT;
               end else begin
                  adv_pos_in = adv_pos_ff - 4'd1;
               end
            end
         end
         S_EMIT: begin
            if (!out_valid_ff || !rsp_stall) begin
               out_valid_in = 1'b1;
               for (int k = 0; k < cokg_pkg::CAND_WORDS; k++) begin
                  words_in[k] = {bytes_ff[4*k+3], bytes_ff[4*k+2],
                                 bytes_ff[4*k+1], bytes_ff[4*k]};
               end
               exh_in   = done_ff;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      bytes_ff    <= bytes_in;
      words_ff    <= words_in;
      rd_idx_ff   <= rd_idx_in;
      adv_pos_ff  <= adv_pos_in;
      pend_idx_ff <= pend_idx_in;
      oob_ff      <= oob_in;
      exh_ff      <= exh_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         for (int i = 0; i < MAX_LEN; i++) begin
            digit_ff[i] <= 8'd0;
         end
         done_ff      <= 1'b0;
         pend_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         digit_ff     <= digit_in;
         done_ff      <= done_in;
         pend_ff      <= pend_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_word0     = words_ff[0];
   assign rsp_word1     = words_ff[1];
   assign rsp_word2     = words_ff[2];
   assign rsp_word3     = words_ff[3];
   assign rsp_exhausted = exh_ff;

`ifndef SYNTHESIS
   // exhausted flag is sticky until a restart leaves the queue
   a_done_sticky: assert property (@(posedge clock) disable iff (reset)
      done_ff && !(q_pop && q_cmd.op == cokg_pkg::OP_RESTART) |=> done_ff)
      else $error("exhausted flag dropped without restart");

   // a new response only follows the emit step
   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(state_ff == S_EMIT))
      else $error("response raised outside emit");

   // table data is only captured for a fetch issued the cycle before
   a_pend_after_fetch: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> $past(state_ff == S_FETCH))
      else $error("table capture without fetch");

   // the queue is not popped while a generate request is in flight
   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FETCH || state_ff == S_ADVANCE) |-> !q_pop)
      else $error("queue popped mid generate");
`endif

endmodule

/* sv/charset_odometer_key_generator_unit.sv */
// channel   direction  handshake            payload
// req_      in         req_valid/req_stall  op, table_slot, char_code, position, start_digit
// rsp_      out        rsp_valid/rsp_stall  word0..word3, exhausted
// csr_      in         csr_valid/csr_ready  csr_index, csr_data
//
// load, set and restart requests complete in the back end's idle state as they are popped
// a generate request steps through fetch, advance and emit (no fetch for zero length): one
// table RAM read port gives one character a cycle, the carry walks one position a cycle
// a two-entry request queue lets requests in while the back end is busy
// the output register holds a response under rsp_stall; the back end waits only when it is full
// reset is synchronous, active high; no clearing pass, table entries are undefined until loaded
module charset_odometer_key_generator_unit #(
   parameter int MAX_LEN    = 15,
   parameter int TABLE_SIZE = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_op,
   input  logic [7:0]  req_table_slot,
   input  logic [7:0]  req_char_code,
   input  logic [3:0]  req_position,
   input  logic [7:0]  req_start_digit,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_word0,
   output logic [31:0] rsp_word1,
   output logic [31:0] rsp_word2,
   output logic [31:0] rsp_word3,
   output logic        rsp_exhausted,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [8:0]  csr_data
);

   logic [3:0] pass_len_ff, pass_len_in;
   logic [8:0] count_ff, count_in;
   logic [3:0] prefix_ff, prefix_in;

   cokg_pkg::cfg_type cfg;
   cokg_pkg::cmd_type q_cmd;
   logic              q_valid;
   logic              q_pop;

   assign csr_ready = 1'b1;

   always_comb begin
      pass_len_in = pass_len_ff;
      count_in    = count_ff;
      prefix_in   = prefix_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            cokg_pkg::CSR_PASSWORD_LENGTH:  pass_len_in = csr_data[3:0];
            cokg_pkg::CSR_CHARSET_COUNT:    count_in    = csr_data;
            cokg_pkg::CSR_FIXED_PREFIX_LEN: prefix_in   = csr_data[3:0];
            default:                        count_in    = count_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pass_len_ff <= 4'd1;
         count_ff    <= 9'd1;
         prefix_ff   <= 4'd0;
      end else begin
         pass_len_ff <= pass_len_in;
         count_ff    <= count_in;
         prefix_ff   <= prefix_in;
      end
   end

   // clamp length and count to what the hardware holds
   always_comb begin
      cfg.len    = (pass_len_ff > 4'(MAX_LEN)) ? 4'(MAX_LEN) : pass_len_ff;
      cfg.count  = (count_ff == 9'd0) ? 9'd1 :
                   (count_ff > 9'(TABLE_SIZE)) ? 9'(TABLE_SIZE) : count_ff;
      cfg.prefix = prefix_ff;
   end

   cokg_front #(
      .MAX_LEN    (MAX_LEN),
      .TABLE_SIZE (TABLE_SIZE)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_op          (req_op),
      .req_table_slot  (req_table_slot),
      .req_char_code   (req_char_code),
      .req_position    (req_position),
      .req_start_digit (req_start_digit),
      .q_valid         (q_valid),
      .q_cmd           (q_cmd),
      .q_pop           (q_pop)
   );

   cokg_back #(
      .MAX_LEN    (MAX_LEN),
      .TABLE_SIZE (TABLE_SIZE)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .q_valid       (q_valid),
      .q_cmd         (q_cmd),
      .q_pop         (q_pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_word0     (rsp_word0),
      .rsp_word1     (rsp_word1),
      .rsp_word2     (rsp_word2),
      .rsp_word3     (rsp_word3),
      .rsp_exhausted (rsp_exhausted)
   );

endmodule

/* dv/testbench.sv */
module testbench;

   localparam int         MAX_POS     = 15;
   localparam int         SETTLE      = 64;
   localparam int         CYCLE_LIMIT = 600000;
   localparam int         PHASES      = 16;
   localparam int         PHASE_ITEMS = 100;
   localparam logic [1:0] CSR_SPARE   = 2'd3;

   typedef struct packed {
      logic [31:0] word0;
      logic [31:0] word1;
      logic [31:0] word2;
      logic [31:0] word3;
      logic        exhausted;
   } cand_type;

   typedef struct packed {
      cokg_pkg::op_type op;
      logic [7:0]       slot;
      logic [7:0]       code;
      logic [3:0]       position;
      logic [7:0]       digit;
   } request_type;

   typedef enum logic {ROW_REQ, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type     kind;
      cokg_pkg::op_type op;
      logic [7:0]       slot;
      logic [7:0]       code;
      logic [3:0]       position;
      logic [7:0]       digit;
      logic [8:0]       len_raw;
      logic [8:0]       count_raw;
      logic [8:0]       prefix_raw;
      logic             typed;
      cand_type         want;
   } plan_row_type;

   localparam cand_type NO_CAND = '0;

   // directed requests; typed rows carry their candidate, the rest go through the predictor
   localparam plan_row_type PLAN [28] = '{
      '{ROW_REQ, cokg_pkg::OP_LOAD, 8'h00, 8'h41, 4'd0, 8'h00,
        9'd0, 9'd0, 9'd0, 1'b0, NO_CAND},
      '{ROW_REQ, cokg_pkg::OP_GENERATE, 8'h00, 8'h00, 4'd0, 8'h00,
        9'd0, 9'd0, 9'd0, 1'b1, {32'h0000_8041, 32'h0, 32'h0, 32'h0, 1'b1}},
      '{ROW_REQ, cokg_pkg::OP_GENERATE, 8'h00, 8'h00, 4'd0, 8'h00,
        9'd0, 9'd0, 9'd0, 1'b1, {32'h0000_8041, 32'h0, 32'h0, 32'h0, 1'b1}},
      '{ROW_REQ, cokg_pkg::OP_RESTART, 8'h00, 8'h00, 4'd0, 8'h00,
        9'd0, 9'd0, 9'd0, 1'b0, NO_CAND},
      '{ROW_REQ, cokg_pkg::OP_LOAD, 8'hFF, 8'hFF, 4'd0, 8'h00,
        9'd0, 9'd0, 9'd0, 1'b0, NO_CAND},
      '{ROW_REQ, cokg_pkg::OP_LOAD, 8'h01, 8'h00, 4'd0, 8'h00,
        9'd0, 9'd0, 9'd0, 1'b0, NO_CAND},
      '{ROW_REQ, cokg_pkg::OP_SET, 8'h00, 8'h00, 4'd0, 8'hFF,
        9'd0, 9'd0, 9'd0, 1'b0, NO_CAND},
      '{ROW_REQ, cokg_pkg::OP_GENERATE, 8'h00, 8'h00, 4'd0, 8'h00,
        9'd0, 9'd0, 9'd0, 1'b1, {32'h0000_80FF, 32'h0, 32'h0, 32'h0, 1'b1}},
      '{ROW_REQ, cokg_pkg::OP_SET, 8'h00, 8'h00, 4'd15, 8'hAA,
        9'd0, 9'd0, 9'd0, 1'b0, NO_CAND},
      '{ROW_REQ, cokg_pkg::OP_GENERATE, 8'h00, 8'h00, 4'd0, 8'h00,
        9'd0, 9'd0, 9'd0, 1'b1, {32'h0000_8041, 32'h0, 32'h0, 32'h0, 1'b1}},
      '{ROW_REQ, cokg_pkg::OP_RESTART, 8'h00, 8'h00, 4'd0, 8'h00,
        9'd0, 9'd0, 9'd0, 1'b0, NO_CAND},
      '{ROW_CSR, cokg_pkg::OP_LOAD, 8'h00, 8'h00, 4'd0, 8'h00,
        9'd15, 9'd511, 9'd14, 1'b0, NO_CAND},
      '{ROW_REQ, cokg_pkg::OP_GENERATE, 8'h00, 8'h00, 4'd0, 8'h00,
        9'd0, 9'd0, 9'd0, 1'b1,
        {32'h4141_4141, 32'h4141_4141, 32'h4141_4141, 32'h8041_4141, 1'b0}},
      '{ROW_REQ, cokg_pkg::OP_SET, 8'h00, 8'h00, 4'd14, 8'hFF,
        9'd0, 9'd0, 9'd0, 1'b0, NO_CAND},
      '{ROW_REQ, cokg_pkg::OP_GENERATE, 8'h00, 8'h00, 4'd0, 8'h00,
        9'd0, 9'd0, 9'd0, 1'b1,
        {32'h4141_4141, 32'h4141_4141, 32'h4141_4141, 32'h80FF_4141, 1'b1}},
      '{ROW_CSR, cokg_pkg::OP_LOAD, 8'h00, 8'h00, 4'd0, 8'h00,
        9'd0, 9'd0, 9'd15, 1'b0, NO_CAND},
      '{ROW_REQ, cokg_pkg::OP_RESTART, 8'h00, 8'h00, 4'd0, 8'h00,
        9'd0, 9'd0, 9'd0, 1'b0, NO_CAND},
      '{ROW_REQ, cokg_pkg::OP_GENERATE, 8'h00, 8'h00, 4'd0, 8'h00,
        9'd0, 9'd0, 9'd0, 1'b1, {32'h0000_0080, 32'h0, 32'h0, 32'h0, 1'b1}},
      '{ROW_CSR, cokg_pkg::OP_LOAD, 8'h00, 8'h00, 4'd0, 8'h00,
        9'd3, 9'd2, 9'd3, 1'b0, NO_CAND},
      '{ROW_REQ, cokg_pkg::OP_LOAD, 8'h01, 8'h7E, 4'd0, 8'h00,
        9'd0, 9'd0, 9'd0, 1'b0, NO_CAND},
      '{ROW_REQ, cokg_pkg::OP_RESTART, 8'h00, 8'h00, 4'd0, 8'h00,
        9'd0, 9'd0, 9'd0, 1'b0, NO_CAND},
      '{ROW_REQ, cokg_pkg::OP_SET, 8'h00, 8'h00, 4'd2, 8'h01,
        9'd0, 9'd0, 9'd0, 1'b0, NO_CAND},
      '{ROW_REQ, cokg_pkg::OP_GENERATE, 8'h00, 8'h00, 4'd0, 8'h00,
        9'd0, 9'd0, 9'd0, 1'b0, NO_CAND},
      '{ROW_CSR, cokg_pkg::OP_LOAD, 8'h00, 8'h00, 4'd0, 8'h00,
        9'd4, 9'd2, 9'd1, 1'b0, NO_CAND},
      '{ROW_REQ, cokg_pkg::OP_RESTART, 8'h00, 8'h00, 4'd0, 8'h00,
        9'd0, 9'd0, 9'd0, 1'b0, NO_CAND},
      '{ROW_REQ, cokg_pkg::OP_GENERATE, 8'h00, 8'h00, 4'd0, 8'h00,
        9'd0, 9'd0, 9'd0, 1'b0, NO_CAND},
      '{ROW_REQ, cokg_pkg::OP_GENERATE, 8'h00, 8'h00, 4'd0, 8'h00,
        9'd0, 9'd0, 9'd0, 1'b0, NO_CAND},
      '{ROW_REQ, cokg_pkg::OP_GENERATE, 8'h00, 8'h00, 4'd0, 8'h00,
        9'd0, 9'd0, 9'd0, 1'b0, NO_CAND}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_op = cokg_pkg::OP_LOAD;
   logic [7:0]  req_table_slot = '0;
   logic [7:0]  req_char_code = '0;
   logic [3:0]  req_position = '0;
   logic [7:0]  req_start_digit = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_word0;
   logic [31:0] rsp_word1;
   logic [31:0] rsp_word2;
   logic [31:0] rsp_word3;
   logic        rsp_exhausted;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = cokg_pkg::CSR_PASSWORD_LENGTH;
   logic [8:0]  csr_data = '0;

   charset_odometer_key_generator_unit dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_op          (req_op),
      .req_table_slot  (req_table_slot),
      .req_char_code   (req_char_code),
      .req_position    (req_position),
      .req_start_digit (req_start_digit),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_word0       (rsp_word0),
      .rsp_word1       (rsp_word1),
      .rsp_word2       (rsp_word2),
      .rsp_word3       (rsp_word3),
      .rsp_exhausted   (rsp_exhausted),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   // predicted state of the odometer
   bit [7:0] char_tab [256];
   bit       slot_loaded [256];
   bit [7:0] digits [MAX_POS];
   bit       spent = 1'b0;
   bit [3:0] cfg_len = 4'd1;
   bit [8:0] cfg_count = 9'd1;
   bit [3:0] cfg_prefix = 4'd0;

   cand_type pending_cands [$];
   cand_type got_cand;
   cand_type want_cand;
   int       mismatches = 0;
   int       cands_checked = 0;
   int       exhaust_seen = 0;
   int       requests_sent = 0;
   int       settings_written = 0;
   int       cycle_count = 0;
   int       stall_left = 0;
   logic     calm = 1'b0;

   initial begin
      forever #10 clock = ~clock;
   end

   function automatic int live_count();
      if (cfg_count == 0) return 1;
      if (cfg_count > 256) return 256;
      return cfg_count;
   endfunction

   // first table entry the next candidate would read without it being loaded
   function automatic int first_unloaded();
      int i;
      for (i = 0; i < cfg_len; i++) begin
         if (!slot_loaded[digits[i]]) return digits[i];
      end
      return -1;
   endfunction

   function automatic void predict_candidate(input request_type r, output bit produced,
                                             output cand_type cand);
      bit [7:0] lane [16];
      int       len;
      int       cnt;
      int       pos;
      int       d;
      int       i;
      bit       carrying;
      produced = 1'b0;
      cand = '0;
      case (r.op)
         cokg_pkg::OP_LOAD: begin
            char_tab[r.slot] = r.code;
            slot_loaded[r.slot] = 1'b1;
         end
         cokg_pkg::OP_SET: begin
            if (r.position < MAX_POS) digits[r.position] = r.digit;
         end
         cokg_pkg::OP_RESTART: begin
            foreach (digits[k]) digits[k] = '0;
            spent = 1'b0;
         end
         default: begin
            len = cfg_len;
            cnt = live_count();
            foreach (lane[k]) lane[k] = '0;
            for (i = 0; i < len; i++) lane[i] = char_tab[digits[i]];
            lane[len] = cokg_pkg::END_MARK;
            cand.word0 = {lane[3], lane[2], lane[1], lane[0]};
            cand.word1 = {lane[7], lane[6], lane[5], lane[4]};
            cand.word2 = {lane[11], lane[10], lane[9], lane[8]};
            cand.word3 = {lane[15], lane[14], lane[13], lane[12]};
            // odometer step, carry towards position 0
            pos = len;
            carrying = 1'b1;
            while (carrying) begin
               if (pos == 0) begin
                  spent = 1'b1;
                  carrying = 1'b0;
               end else begin
                  d = digits[pos - 1] + 1;
                  if (d < cnt) begin
                     digits[pos - 1] = d[7:0];
                     carrying = 1'b0;
                  end else begin
                     digits[pos - 1] = '0;
                     pos--;
                     if (pos == 0 || pos - 1 < cfg_prefix) begin
                        spent = 1'b1;
                        carrying = 1'b0;
                     end
                  end
               end
            end
            cand.exhausted = spent;
            produced = 1'b1;
         end
      endcase
   endfunction

   task automatic issue(input request_type r, input bit typed, input cand_type want);
      bit       produced;
      cand_type cand;
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_op          <= r.op;
      req_table_slot  <= r.slot;
      req_char_code   <= r.code;
      req_position    <= r.position;
      req_start_digit <= r.digit;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_candidate(r, produced, cand);
      if (produced) pending_cands.push_back(typed ? want : cand);
      if (!(r.op == cokg_pkg::OP_SET && r.position >= MAX_POS)) requests_sent++;
   endtask

   // a generate only goes out once every table entry it reads has been loaded
   task automatic send(input request_type r, input bit typed, input cand_type want);
      request_type fill;
      int          slot;
      if (r.op == cokg_pkg::OP_GENERATE) begin
         slot = first_unloaded();
         while (slot >= 0) begin
            fill = '{cokg_pkg::OP_LOAD, slot[7:0], 8'($urandom), 4'($urandom),
                     8'($urandom)};
            issue(fill, 1'b0, NO_CAND);
            slot = first_unloaded();
         end
      end
      issue(r, typed, want);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [8:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         cokg_pkg::CSR_PASSWORD_LENGTH:  cfg_len = value[3:0];
         cokg_pkg::CSR_CHARSET_COUNT:    cfg_count = value;
         cokg_pkg::CSR_FIXED_PREFIX_LEN: cfg_prefix = value[3:0];
         default: ;
      endcase
   endtask

   task automatic program_regs(input logic [8:0] len_raw, input logic [8:0] count_raw,
                               input logic [8:0] prefix_raw);
      write_reg(cokg_pkg::CSR_PASSWORD_LENGTH, len_raw);
      write_reg(cokg_pkg::CSR_CHARSET_COUNT, count_raw);
      write_reg(cokg_pkg::CSR_FIXED_PREFIX_LEN, prefix_raw);
      write_reg(CSR_SPARE, 9'($urandom));
      csr_valid <= 1'b0;
      settings_written++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_cands.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   function automatic request_type random_request(input cokg_pkg::op_type op);
      request_type r;
      r = '{op, 8'($urandom), 8'($urandom), 4'($urandom), 8'($urandom)};
      return r;
   endfunction

   // restart, seed some digits, maybe load a table entry, then run the odometer
   task automatic odometer_run();
      request_type r;
      int          cnt;
      cnt = live_count();
      send(random_request(cokg_pkg::OP_RESTART), 1'b0, NO_CAND);
      repeat ($urandom_range(0, 3)) begin
         r = random_request(cokg_pkg::OP_SET);
         r.position = (cfg_len == 0) ? 4'd0 : 4'($urandom_range(0, cfg_len - 1));
         r.digit = 8'($urandom_range(0, cnt - 1));
         send(r, 1'b0, NO_CAND);
      end
      if ($urandom_range(0, 3) == 0) begin
         r = random_request(cokg_pkg::OP_LOAD);
         r.slot = 8'($urandom_range(0, cnt - 1));
         send(r, 1'b0, NO_CAND);
      end
      repeat ($urandom_range(2, 20)) begin
         send(random_request(cokg_pkg::OP_GENERATE), 1'b0, NO_CAND);
      end
   endtask

   task automatic noise_run();
      repeat ($urandom_range(1, 6)) begin
         send(random_request(cokg_pkg::op_type'($urandom_range(0, 3))), 1'b0, NO_CAND);
      end
   endtask

   always @(posedge clock) begin
      if (reset || calm) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 5) == 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= $urandom_range(0, 7);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         got_cand = {rsp_word0, rsp_word1, rsp_word2, rsp_word3, rsp_exhausted};
         if (pending_cands.size() == 0) begin
            if (mismatches < 10) begin
               $display("cycle %0d: candidate %h %h %h %h x%0b with no request pending",
                        cycle_count, got_cand.word0, got_cand.word1, got_cand.word2,
                        got_cand.word3, got_cand.exhausted);
            end
            mismatches++;
         end else begin
            want_cand = pending_cands.pop_front();
            cands_checked++;
            if (got_cand.exhausted) exhaust_seen++;
            if (got_cand.word0 !== want_cand.word0 || got_cand.word1 !== want_cand.word1 ||
                got_cand.word2 !== want_cand.word2 || got_cand.word3 !== want_cand.word3 ||
                got_cand.exhausted !== want_cand.exhausted) begin
               if (mismatches < 10) begin
                  $display("cycle %0d: expected %h %h %h %h x%0b, got %h %h %h %h x%0b",
                           cycle_count, want_cand.word0, want_cand.word1, want_cand.word2,
                           want_cand.word3, want_cand.exhausted, got_cand.word0,
                           got_cand.word1, got_cand.word2, got_cand.word3,
                           got_cand.exhausted);
               end
               mismatches++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timed out after %0d cycles, %0d candidates outstanding",
                  cycle_count, pending_cands.size());
         $display("testbench: errors");
         $finish;
      end
   end

   initial begin
      request_type r;
      logic [8:0]  len_raw;
      logic [8:0]  count_raw;
      logic [8:0]  prefix_raw;
      int          phase_start;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (PLAN[i]) begin
         if (PLAN[i].kind == ROW_CSR) begin
            drain();
            program_regs(PLAN[i].len_raw, PLAN[i].count_raw, PLAN[i].prefix_raw);
         end else begin
            r = '{PLAN[i].op, PLAN[i].slot, PLAN[i].code, PLAN[i].position, PLAN[i].digit};
            send(r, PLAN[i].typed, PLAN[i].want);
         end
      end

      for (int ph = 0; ph < PHASES; ph++) begin
         drain();
         if (ph >= PHASES - 2) calm <= 1'b1;
         case ($urandom_range(0, 9))
            0: begin
               len_raw    = 9'($urandom);
               count_raw  = 9'($urandom);
               prefix_raw = 9'($urandom);
            end
            1: begin
               len_raw    = 9'd15;
               count_raw  = 9'($urandom_range(256, 511));
               prefix_raw = 9'($urandom_range(0, 15));
            end
            default: begin
               len_raw    = 9'($urandom_range(1, 4));
               count_raw  = 9'($urandom_range(1, 4));
               prefix_raw = 9'($urandom_range(0, len_raw));
            end
         endcase
         program_regs(len_raw, count_raw, prefix_raw);
         phase_start = requests_sent;
         while (requests_sent - phase_start < PHASE_ITEMS) begin
            if ($urandom_range(0, 3) != 0) odometer_run();
            else noise_run();
         end
      end

      drain();
      $display("%0d requests over %0d register settings, %0d candidates checked",
               requests_sent, settings_written, cands_checked);
      $display("%0d candidates came back flagged exhausted, %0d mismatches",
               exhaust_seen, mismatches);
      if (mismatches == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end

endmodule

/* charset_odometer_key_generator_unit.f */
sv/cokg_pkg.sv
sv/cokg_ram.sv
sv/cokg_front.sv
sv/cokg_back.sv
sv/charset_odometer_key_generator_unit.sv
dv/testbench.sv
